// File: rtl/core/can_tunnel_frame_deframer_top_macros.svh
// Assertion macros shared by the deframer RTL.
// With SYNTH defined, every macro expands to nothing.
`ifndef CAN_TUNNEL_FRAME_DEFRAMER_TOP_MACROS_SVH
`define CAN_TUNNEL_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTH

// Property checked at every clock edge outside of reset.
`define CTTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define CTTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CTTD_ASSERT(lbl, clk, rst, prop, msg)
`define CTTD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/cttd_pkg.sv
`default_nettype none

package cttd_pkg;

   // Frame geometry.
   localparam int unsigned WinDepth   = 12;
   localparam int unsigned DataBytes  = 8;
   localparam int unsigned IdLowPos   = 2;
   localparam int unsigned IdHighPos  = 3;
   localparam int unsigned LengthPos  = 4;
   localparam int unsigned DataPos    = 5;

   // Sync word and length limit.
   localparam logic [7:0] SyncFirst  = 8'hCA;
   localparam logic [7:0] SyncSecond = 8'hFE;
   localparam logic [7:0] MaxData    = 8'd8;

   // Input transaction.
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       restart;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [15:0] frame_id;
      logic [3:0]  frame_length;
      logic [63:0] frame_payload;
   } rsp_type;

   typedef logic [WinDepth-1:0][7:0] window_type;

   // Window contents as seen by the frame checker.
   typedef struct packed {
      logic       full;
      window_type bytes;
   } window_status_type;

   // Checker verdict and the decoded frame.
   typedef struct packed {
      logic    hit;
      rsp_type rsp;
   } check_type;

endpackage

`default_nettype wire

// File: rtl/core/cttd_frame_check.sv
`default_nettype none

module cttd_frame_check (
   input  wire cttd_pkg::window_status_type win,
   input  wire cttd_pkg::req_type           req,
   output cttd_pkg::check_type              chk
);

   logic [cttd_pkg::WinDepth:0][7:0] frame;
   logic [7:0]                       len;
   logic                             full_eff;
   logic [63:0]                      payload;

   // The 13-byte frame is the held window plus the new byte.
   always_comb begin
      frame = {req.stream_byte, win.bytes};
   end

   // A restart empties the window, so no frame can be checked on that byte.
   assign full_eff = win.full && !req.restart;
   assign len      = frame[cttd_pkg::LengthPos];

   // Data bytes at or beyond the length read as zero.
   always_comb begin
      payload = '0;
      for (int i = 0; i < int'(cttd_pkg::DataBytes); i++) begin
         if (8'(i) < len) begin
            payload[8*i +: 8] = frame[cttd_pkg::DataPos + i];
         end
      end
   end

   always_comb begin
      chk.hit = full_eff
             && (frame[0] == cttd_pkg::SyncFirst)
             && (frame[1] == cttd_pkg::SyncSecond)
             && (len <= cttd_pkg::MaxData);
      chk.rsp.frame_id      = {frame[cttd_pkg::IdHighPos], frame[cttd_pkg::IdLowPos]};
      chk.rsp.frame_length  = len[3:0];
      chk.rsp.frame_payload = payload;
   end

endmodule

`default_nettype wire

// File: rtl/core/cttd_window.sv
`default_nettype none

`include "can_tunnel_frame_deframer_top_macros.svh"

module cttd_window (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire cttd_pkg::req_type     req,
   input  wire logic                  hit,
   output cttd_pkg::window_status_type win
);

   localparam logic [3:0] FillFull = 4'(cttd_pkg::WinDepth);

   cttd_pkg::window_type window_ff, window_in;
   logic [3:0]           fill_ff, fill_in;
   logic [3:0]           fill_eff;

   // A restart drops the held bytes before this byte is taken.
   assign fill_eff = req.restart ? 4'd0 : fill_ff;

   // Window update for one processed byte: append, empty on a frame, or slide.
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (step) begin
         if (fill_eff != FillFull) begin
            window_in[fill_eff] = req.stream_byte;
            fill_in             = fill_eff + 4'd1;
         end else if (hit) begin
            fill_in = 4'd0;
         end else begin
            window_in = {req.stream_byte, window_ff[cttd_pkg::WinDepth-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 4'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Window bytes are payload and need no reset.
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign win.full  = (fill_ff == FillFull);
   assign win.bytes = window_ff;

   `CTTD_ASSERT(fill_in_range, clock, reset, fill_ff <= FillFull, "window fill above depth")
   `CTTD_ASSERT(frame_empties_window, clock, reset, step && hit |=> fill_ff == 4'd0, "window not emptied after a frame")
   `CTTD_ASSERT(append_grows_fill, clock, reset, step && !req.restart && fill_ff != FillFull |=> fill_ff == $past(fill_ff) + 4'd1, "append did not grow the window")

endmodule

`default_nettype wire

// File: rtl/core/can_tunnel_frame_deframer_top.sv
// Deframer for a byte stream carrying fixed 13-byte frames (sync 0xCA 0xFE,
// 16-bit little-endian identifier, length 0..8, eight data bytes). The block
// takes one byte per clock cycle while req_ready is high. A byte is held in
// the input register and checked against the window; a byte completing a
// valid frame writes its result into the output register. The rate is set
// by the window update, which completes as the byte leaves the input register,
// so bytes may arrive back to back; req_ready drops only while a result waits
// in the output register and the byte in the input register would make a new
// one. Bytes beyond the frame length come out as zero. A byte with restart set
// empties the window and starts a new stream. No clearing pass follows reset.
`default_nettype none

`include "can_tunnel_frame_deframer_top_macros.svh"

module can_tunnel_frame_deframer_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire cttd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output cttd_pkg::rsp_type  rsp_data
);

   logic                        s1_valid_ff, s1_valid_in;
   cttd_pkg::req_type           s1_data_ff, s1_data_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cttd_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   cttd_pkg::window_status_type win;
   cttd_pkg::check_type         chk;
   logic                        process;
   logic                        req_take;

   cttd_window u_window (
      .clock (clock),
      .reset (reset),
      .step  (process),
      .req   (s1_data_ff),
      .hit   (chk.hit),
      .win   (win)
   );

   cttd_frame_check u_check (
      .win (win),
      .req (s1_data_ff),
      .chk (chk)
   );

   // A registered byte is processed unless its result has nowhere to go.
   assign process   = s1_valid_ff && (!chk.hit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || process;
   assign req_take  = req_valid && req_ready;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (process) begin
         s1_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (process && chk.hit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chk.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CTTD_ASSERT(no_result_overwrite, clock, reset, process && chk.hit |-> !rsp_valid_ff || rsp_ready, "pending result overwritten")
   `CTTD_ASSERT(result_length_valid, clock, reset, rsp_valid_ff |-> rsp_data_ff.frame_length <= 4'd8, "result length above eight")
   `CTTD_ASSERT(idle_after_reset, clock, reset, $past(reset) |-> !s1_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: tb/sv/cttd_frame_checker.sv
// Watches both channels of the deframer, keeps its own copy of the byte
// window, predicts which input transactions complete a valid frame, and
// compares every result transaction with the oldest frame still due.
module cttd_frame_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cttd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cttd_pkg::rsp_type rsp_data,
   output int unsigned       failure_count,
   output int unsigned       frames_pending,
   output int unsigned       frames_checked
);
   import cttd_pkg::*;

   // Bytes held since the last frame or restart, oldest at entry 0.
   logic [7:0]        held_bytes [WinDepth];
   int unsigned       held_count;
   rsp_type           frames_due [$];

   // Takes one stream byte into the window and queues a frame if it completes one.
   task automatic shift_in_byte(input req_type item);
      logic [7:0] frame_bytes [WinDepth+1];
      logic [7:0] length_byte;
      rsp_type    decoded;
      if (item.restart) begin
         held_count = 0;
      end
      if (held_count < WinDepth) begin
         held_bytes[held_count] = item.stream_byte;
         held_count++;
         return;
      end
      for (int i = 0; i < WinDepth; i++) begin
         frame_bytes[i] = held_bytes[i];
      end
      frame_bytes[WinDepth] = item.stream_byte;
      length_byte = frame_bytes[LengthPos];

      // A bad sync word or an oversized length slides the window by one byte.
      if (frame_bytes[0] != SyncFirst || frame_bytes[1] != SyncSecond ||
          length_byte > MaxData) begin
         for (int i = 0; i < WinDepth - 1; i++) begin
            held_bytes[i] = held_bytes[i+1];
         end
         held_bytes[WinDepth-1] = item.stream_byte;
         return;
      end

      // Data bytes at or beyond the length stay zero.
      decoded.frame_id      = {frame_bytes[IdHighPos], frame_bytes[IdLowPos]};
      decoded.frame_length  = length_byte[3:0];
      decoded.frame_payload = '0;
      for (int i = 0; i < DataBytes; i++) begin
         if (i < length_byte) begin
            decoded.frame_payload[8*i +: 8] = frame_bytes[DataPos+i];
         end
      end
      frames_due.push_back(decoded);
      held_count = 0;
   endtask

   // Compares one result transaction with the oldest frame due.
   task automatic check_frame(input rsp_type actual);
      rsp_type wanted;
      if (frames_due.size() == 0) begin
         $display("%0t: result with no frame due: id %h length %0d payload %h",
                  $time, actual.frame_id, actual.frame_length, actual.frame_payload);
         failure_count++;
         return;
      end
      wanted = frames_due.pop_front();
      frames_checked++;
      if (actual.frame_id !== wanted.frame_id) begin
         $display("%0t: frame_id mismatch, expected %h, actual %h",
                  $time, wanted.frame_id, actual.frame_id);
         failure_count++;
      end
      if (actual.frame_length !== wanted.frame_length) begin
         $display("%0t: frame_length mismatch, expected %0d, actual %0d",
                  $time, wanted.frame_length, actual.frame_length);
         failure_count++;
      end
      if (actual.frame_payload !== wanted.frame_payload) begin
         $display("%0t: frame_payload mismatch, expected %h, actual %h",
                  $time, wanted.frame_payload, actual.frame_payload);
         failure_count++;
      end
   endtask

   // Results are checked before the new byte is taken; a byte never yields a
   // result in the cycle it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         frames_due.delete();
         failure_count  = 0;
         frames_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_frame(rsp_data);
         end
         if (req_valid && req_ready) begin
            shift_in_byte(req_data);
         end
      end
      frames_pending <= frames_due.size();
   end

endmodule

// File: tb/sv/can_tunnel_frame_deframer_top_tb.sv
// Drives a byte stream of frames, noise, broken frames and restarts into the
// deframer, lets the receiver stall at random, and reports the verdict.
module can_tunnel_frame_deframer_top_tb;
   import cttd_pkg::*;

   localparam int unsigned ItemTarget  = 1100;
   localparam int unsigned QuietLimit  = 1000;
   localparam int unsigned HoldCycles  = 120;
   localparam int unsigned SettleTime  = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned failure_count;
   int unsigned frames_pending;
   int unsigned frames_checked;

   int unsigned bytes_sent    = 0;
   int unsigned restarts_sent = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned holds_asked   = 0;
   int unsigned holds_served  = 0;
   bit          req_idle_on   = 1'b0;
   bit          rsp_idle_on   = 1'b0;

   always #5 clock = ~clock;

   can_tunnel_frame_deframer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cttd_frame_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .failure_count  (failure_count),
      .frames_pending (frames_pending),
      .frames_checked (frames_checked)
   );

   // Ends the run when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QuietLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus a long hold-off when one is asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles - 1) @(posedge clock);
            holds_served++;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one byte, after an optional idle burst, and returns once accepted.
   task automatic send_byte(input logic [7:0] value, input logic restart_flag);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{stream_byte: value, restart: restart_flag};
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (restart_flag) begin
         restarts_sent++;
      end
   endtask

   // Sends the first cut_len bytes of a frame; the sync word may be corrupted
   // and a restart may land on any byte.
   task automatic send_frame(input logic [15:0] id, input logic [7:0] length_byte,
                             input logic [63:0] data, input int restart_at,
                             input int cut_len, input logic [15:0] sync_flip);
      logic [7:0] frame_bytes [WinDepth+1];
      frame_bytes[0]         = SyncFirst ^ sync_flip[7:0];
      frame_bytes[1]         = SyncSecond ^ sync_flip[15:8];
      frame_bytes[IdLowPos]  = id[7:0];
      frame_bytes[IdHighPos] = id[15:8];
      frame_bytes[LengthPos] = length_byte;
      for (int i = 0; i < DataBytes; i++) begin
         frame_bytes[DataPos+i] = data[8*i +: 8];
      end
      for (int i = 0; i < cut_len; i++) begin
         send_byte(frame_bytes[i], i == restart_at);
      end
   endtask

   // Random frame content, leaning on the length and identifier extremes.
   task automatic send_random_frame(input int restart_at, input int cut_len,
                                    input logic [15:0] sync_flip, input bit legal_length);
      logic [7:0]  length_byte;
      logic [15:0] id;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         length_byte = 8'd0;
      end else if (pick < 4) begin
         length_byte = MaxData;
      end else if (pick == 4 && !legal_length) begin
         length_byte = 8'($urandom_range(9, 255));
      end else begin
         length_byte = 8'($urandom_range(0, 8));
      end
      pick = $urandom_range(0, 7);
      id = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      send_frame(id, length_byte, {$urandom, $urandom}, restart_at, cut_len, sync_flip);
   endtask

   // Stops offering bytes until every predicted frame has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned kind;
      bit          pressure_done;
      pressure_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: a stray byte ahead of a full-length frame forces one slide,
      // then a frame whose length is above the limit.
      send_byte(8'h00, 1'b1);
      send_frame(16'hFFFF, MaxData, 64'hFF55_AA7F_0180_FF00, -1, WinDepth + 1, 16'h0000);
      send_frame(16'h0000, 8'd9, 64'h1111_2222_3333_4444, -1, WinDepth + 1, 16'h0000);
      rsp_idle_on <= 1'b1;
      wait_for_drain();
      req_idle_on = 1'b1;

      // Random stream: mostly well-formed frames, some noise and broken ones.
      while (bytes_sent < ItemTarget) begin
         if (bytes_sent + 150 >= ItemTarget) begin
            req_idle_on = 1'b0;
            rsp_idle_on <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            req_idle_on = $urandom_range(0, 1);
            rsp_idle_on <= $urandom_range(0, 1);
         end

         // The receiver holds off while frames keep coming, then the sender pauses.
         if (!pressure_done && bytes_sent >= 400) begin
            pressure_done = 1'b1;
            req_idle_on = 1'b0;
            holds_asked <= holds_asked + 1;
            repeat (8) send_random_frame(-1, WinDepth + 1, 16'h0000, 1'b1);
            wait_for_drain();
         end

         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            send_random_frame(($urandom_range(0, 4) == 0) ? 0 : -1, WinDepth + 1,
                              16'h0000, 1'b0);
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 5)) begin
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end else if (kind == 8) begin
            if ($urandom_range(0, 1) == 0) begin
               send_random_frame(-1, $urandom_range(1, WinDepth), 16'h0000, 1'b0);
            end else begin
               send_random_frame($urandom_range(1, WinDepth), WinDepth + 1, 16'h0000, 1'b0);
            end
         end else begin
            send_random_frame(-1, WinDepth + 1, 16'($urandom_range(1, 65535)), 1'b0);
         end
      end

      // Drain, then give the block time to show any result nobody expects.
      wait_for_drain();
      repeat (SettleTime) @(posedge clock);

      $display("Sent %0d stream bytes (%0d with restart) and checked %0d decoded frames,",
               bytes_sent, restarts_sent, frames_checked);
      $display("including a long output hold-off and a full drain pause.");
      if (failure_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cttd_pkg.sv
rtl/core/cttd_frame_check.sv
rtl/core/cttd_window.sv
rtl/core/can_tunnel_frame_deframer_top.sv
tb/sv/cttd_frame_checker.sv
tb/sv/can_tunnel_frame_deframer_top_tb.sv
